@@ src/fme_pkg.sv @@
`default_nettype none
package fme_pkg;

   localparam int MAX_CLUSTERS = 16;
   localparam int MAX_FEATURES = 16;
   localparam int FEATURE_BITS = 16;
   localparam int CLUS_W = $clog2(MAX_CLUSTERS);
   localparam int FEAT_W = $clog2(MAX_FEATURES);
   localparam int CADDR_W = CLUS_W + FEAT_W;
   localparam int DIST_W = 37;
   localparam int LOG_W = 22;
   localparam int MANT_W = 31;
   localparam int TOTAL_W = 35;
   localparam int NUM_W = 47;
   localparam int MEMB_W = 16;
   localparam int ROOT_W = 30;
   localparam int ROOT_N = 16;

   typedef enum logic {
      OP_LOAD     = 1'b0,
      OP_CLASSIFY = 1'b1
   } op_type;

   localparam logic [1:0] CSR_CLUSTERS = 2'd0;
   localparam logic [1:0] CSR_FEATURES = 2'd1;
   localparam logic [1:0] CSR_POWER    = 2'd2;

   typedef struct packed {
      op_type                          op;
      logic [3:0]                      cluster_index;
      logic [3:0]                      feature_index;
      logic signed [FEATURE_BITS-1:0]  feature_value;
   } req_type;

   typedef struct packed {
      logic [3:0]        result_cluster;
      logic [MEMB_W-1:0] membership;
      logic              exact_hit;
      logic [3:0]        best_cluster;
      logic              last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE, S_DRD, S_DMUL, S_DACC,
      S_LLOAD, S_LNORM, S_LSQ, S_LADJ,
      S_EMUL, S_EADJ, S_WMUL, S_WADJ, S_WEND,
      S_DIVGO, S_DIVWAIT, S_EMIT
   } state_type;

   typedef logic [ROOT_W-1:0] root_tab_type [ROOT_N];

   function automatic logic [63:0] isqrt_f(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] one;
      logic [63:0] rem;
      res = '0;
      one = 64'd1 << 62;
      rem = v;
      for (int i = 0; i < 32; i++) begin
         if (rem >= res + one) begin
            rem = rem - (res + one);
            res = (res >> 1) + one;
         end else begin
            res = res >> 1;
         end
         one = one >> 2;
      end
      return res;
   endfunction

   // successive square roots of one half, Q0.30
   function automatic root_tab_type root_tab_f();
      root_tab_type t;
      logic [63:0]  c;
      c = isqrt_f(64'd1 << 59);
      for (int i = 0; i < ROOT_N; i++) begin
         t[i] = c[ROOT_W-1:0];
         c = isqrt_f(c << 30);
      end
      return t;
   endfunction

   localparam root_tab_type ROOT_TAB = root_tab_f();

endpackage
`default_nettype wire

@@ src/fme_mul.sv @@
`default_nettype none
module fme_mul (
   input  wire logic        clock,
   input  wire logic [31:0] mul_a,
   input  wire logic [31:0] mul_b,
   output logic      [63:0] prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= {32'd0, mul_a} * {32'd0, mul_b};
   end
endmodule
`default_nettype wire

@@ src/fme_div.sv @@
`default_nettype none
module fme_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [fme_pkg::NUM_W-1:0]   num,
   input  wire logic [fme_pkg::TOTAL_W-1:0] den,
   output logic                            done_ff,
   output logic      [fme_pkg::MEMB_W-1:0]  quot_ff
);
   import fme_pkg::*;

   logic                  busy_ff;
   logic [3:0]            cnt_ff;
   logic [TOTAL_W-1:0]    rem_ff;
   logic [MEMB_W-1:0]     low_ff;
   logic [TOTAL_W:0]      trial;
   logic [TOTAL_W:0]      diff;
   logic                  ge;

   // quotient fits 16 bits, so the top of the numerator starts below den
   always_comb begin
      trial = {rem_ff, low_ff[MEMB_W-1]};
      diff  = trial - {1'b0, den};
      ge    = trial >= {1'b0, den};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 4'd15) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= {{(TOTAL_W-(NUM_W-MEMB_W)){1'b0}}, num[NUM_W-1:MEMB_W]};
         low_ff <= num[MEMB_W-1:0];
         cnt_ff <= 4'd0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? diff[TOTAL_W-1:0] : trial[TOTAL_W-1:0];
         low_ff  <= {low_ff[MEMB_W-2:0], 1'b0};
         quot_ff <= {quot_ff[MEMB_W-2:0], ge};
         cnt_ff  <= cnt_ff + 4'd1;
      end
   end
endmodule
`default_nettype wire

@@ src/fme_cmem.sv @@
`default_nettype none
module fme_cmem (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             we,
   input  wire logic [fme_pkg::CADDR_W-1:0]       waddr,
   input  wire logic [fme_pkg::FEATURE_BITS-1:0]  wdata,
   input  wire logic [fme_pkg::CADDR_W-1:0]       raddr,
   output logic      [fme_pkg::FEATURE_BITS-1:0]  rdata
);
   import fme_pkg::*;

   localparam int DEPTH = MAX_CLUSTERS * MAX_FEATURES;

   logic [FEATURE_BITS-1:0] mem [DEPTH];
   logic [DEPTH-1:0]        valid_ff;
   logic [FEATURE_BITS-1:0] rd_ff;
   logic                    rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (we) begin
         valid_ff[waddr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[raddr];
      rv_ff <= valid_ff[raddr];
   end

   // never-written centres read as zero
   assign rdata = rv_ff ? rd_ff : '0;
endmodule
`default_nettype wire

@@ src/fuzzy_membership_engine_core.sv @@
`default_nettype none
// channel   dir  handshake              payload
// req       in   req_valid/req_ready    req_data  (op, cluster_index, feature_index, value)
// rsp       out  rsp_valid/rsp_ready    rsp_data  (cluster, membership, hit, best, last)
// csr       in   csr_we                 csr_index, csr_wdata
// Load and non-final classify beats are accepted in the idle state and leave it idle.
// Final feature: distances (read, square, accumulate per centre feature), then per cluster
// log2 (normalize shift plus 16 squarings), exponent weighting and division,
// all on one shared 32x32 multiplier and one radix-2 divider; exact hits skip to output.
// Then C result beats; req_ready stays low until the last one is taken.
// Reset is synchronous and clears the centre store valid bits at once.
module fuzzy_membership_engine_core (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire fme_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output fme_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);
   import fme_pkg::*;

   state_type state_ff, state_in;

   logic [4:0]  ncr_ff, nfr_ff;
   logic [15:0] pe_ff;
   logic [4:0]  nc_eff, nf_eff;

   logic [CLUS_W-1:0]       clus_ff;
   logic [FEAT_W-1:0]       feat_ff;
   logic [3:0]              step_ff;
   logic [DIST_W-1:0]       acc_ff;
   logic                    hit_ff;
   logic [CLUS_W-1:0]       best_ff;
   logic [MEMB_W-1:0]       bestv_ff;
   logic [DIST_W-1:0]       xw_ff;
   logic [5:0]              msb_ff;
   logic [MANT_W-1:0]       m_ff;
   logic [15:0]             frac_ff;
   logic [LOG_W-1:0]        lmin_ff;
   logic                    big_ff;
   logic [4:0]              shamt_ff;
   logic [TOTAL_W-1:0]      total_ff;
   logic [FEATURE_BITS-1:0] pt_rd_ff;

   logic [FEATURE_BITS-1:0] pt_mem   [MAX_FEATURES];
   logic [DIST_W-1:0]       dist_mem [MAX_CLUSTERS];
   logic [LOG_W-1:0]        lg_mem   [MAX_CLUSTERS];
   logic [MANT_W-1:0]       w_mem    [MAX_CLUSTERS];
   logic [MEMB_W-1:0]       memb_mem [MAX_CLUSTERS];

   logic                    req_fire, rsp_fire, last_feat, last_clus, acc_zero;
   logic [31:0]             mul_a, mul_b;
   logic [63:0]             prod_ff;
   logic                    cmem_we;
   logic [FEATURE_BITS-1:0] cmem_rdata;
   logic                    div_start, div_done;
   logic [MEMB_W-1:0]       div_quot;
   logic [NUM_W-1:0]        div_num;

   logic signed [FEATURE_BITS:0] diff;
   logic [FEATURE_BITS:0]   absd;
   logic [DIST_W-1:0]       acc_sum;
   logic [31:0]             sq;
   logic [MANT_W-1:0]       m_sq;
   logic [15:0]             frac_sq;
   logic [LOG_W-1:0]        lg_new;
   logic [LOG_W-1:0]        ldiff;
   logic [38:0]             e_sum;
   logic [26:0]             e_val;
   logic [MANT_W-1:0]       w_val;

   always_comb begin
      nc_eff = (ncr_ff == 5'd0) ? 5'd1 : (ncr_ff > 5'(MAX_CLUSTERS)) ? 5'(MAX_CLUSTERS) : ncr_ff;
      nf_eff = (nfr_ff == 5'd0) ? 5'd1 : (nfr_ff > 5'(MAX_FEATURES)) ? 5'(MAX_FEATURES) : nfr_ff;
      last_feat = {1'b0, feat_ff} == nf_eff - 5'd1;
      last_clus = {1'b0, clus_ff} == nc_eff - 5'd1;
      req_fire  = req_valid && req_ready;
      rsp_fire  = rsp_valid && rsp_ready;

      diff    = $signed({pt_rd_ff[FEATURE_BITS-1], pt_rd_ff})
              - $signed({cmem_rdata[FEATURE_BITS-1], cmem_rdata});
      absd    = diff[FEATURE_BITS] ? 17'(-diff) : diff;
      acc_sum = acc_ff + {3'd0, prod_ff[33:0]};
      acc_zero = acc_sum == '0;

      sq      = prod_ff[61:30];
      m_sq    = sq[31] ? sq[31:1] : sq[30:0];
      frac_sq = sq[31] ? (frac_ff | (16'h8000 >> step_ff)) : frac_ff;
      lg_new  = {msb_ff, frac_sq};

      ldiff   = lg_mem[clus_ff] - lmin_ff;
      e_sum   = {1'b0, prod_ff[37:0]} + 39'd2048;
      e_val   = e_sum[38:12];
      w_val   = big_ff ? '0 : (m_ff >> shamt_ff);

      div_num = {1'b0, w_mem[clus_ff], 15'd0} + {13'd0, total_ff[TOTAL_W-1:1]};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:
            if (req_fire && req_data.op == OP_CLASSIFY &&
                {1'b0, req_data.feature_index} == nf_eff - 5'd1) begin
               state_in = S_DRD;
            end
         S_DRD:  state_in = S_DMUL;
         S_DMUL: state_in = S_DACC;
         S_DACC:
            if (last_feat && last_clus) begin
               state_in = (hit_ff || acc_zero) ? S_EMIT : S_LLOAD;
            end else begin
               state_in = S_DRD;
            end
         S_LLOAD: state_in = S_LNORM;
         S_LNORM: if (xw_ff[DIST_W-1]) state_in = S_LSQ;
         S_LSQ:   state_in = S_LADJ;
         S_LADJ:
            if (step_ff == 4'd15) begin
               state_in = last_clus ? S_EMUL : S_LLOAD;
            end else begin
               state_in = S_LSQ;
            end
         S_EMUL: state_in = S_EADJ;
         S_EADJ: state_in = S_WMUL;
         S_WMUL: state_in = S_WADJ;
         S_WADJ: state_in = (step_ff == 4'd15) ? S_WEND : S_WMUL;
         S_WEND: state_in = last_clus ? S_DIVGO : S_EMUL;
         S_DIVGO: state_in = S_DIVWAIT;
         S_DIVWAIT:
            if (div_done) begin
               state_in = last_clus ? S_EMIT : S_DIVGO;
            end
         S_EMIT: if (rsp_fire && last_clus) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and unit controls
   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      div_start = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      case (state_ff)
         S_IDLE:  req_ready = 1'b1;
         S_DMUL: begin
            mul_a = {15'd0, absd};
            mul_b = {15'd0, absd};
         end
         S_LSQ: begin
            mul_a = {1'b0, m_ff};
            mul_b = {1'b0, m_ff};
         end
         S_EMUL: begin
            mul_a = {16'd0, pe_ff};
            mul_b = {10'd0, ldiff};
         end
         S_WMUL: begin
            mul_a = {1'b0, m_ff};
            mul_b = {2'd0, ROOT_TAB[step_ff]};
         end
         S_DIVGO: div_start = 1'b1;
         S_EMIT:  rsp_valid = 1'b1;
         default: ;
      endcase
      cmem_we = req_fire && req_data.op == OP_LOAD;
      rsp_data.result_cluster = clus_ff;
      rsp_data.membership     = hit_ff ? ((clus_ff == best_ff) ? 16'h8000 : 16'h0000)
                                       : memb_mem[clus_ff];
      rsp_data.exact_hit      = hit_ff;
      rsp_data.best_cluster   = best_ff;
      rsp_data.last           = last_clus;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ncr_ff   <= 5'd2;
         nfr_ff   <= 5'd2;
         pe_ff    <= 16'd4096;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_CLUSTERS: ncr_ff <= csr_wdata[4:0];
               CSR_FEATURES: nfr_ff <= csr_wdata[4:0];
               CSR_POWER:    pe_ff  <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE:
            if (req_fire) begin
               if (req_data.op == OP_CLASSIFY) begin
                  pt_mem[req_data.feature_index] <= req_data.feature_value;
               end
               clus_ff  <= '0;
               feat_ff  <= '0;
               acc_ff   <= '0;
               hit_ff   <= 1'b0;
               lmin_ff  <= '1;
               total_ff <= '0;
            end
         S_DRD: pt_rd_ff <= pt_mem[feat_ff];
         S_DACC:
            if (last_feat) begin
               dist_mem[clus_ff] <= acc_sum;
               acc_ff  <= '0;
               feat_ff <= '0;
               if (acc_zero && !hit_ff) begin
                  hit_ff  <= 1'b1;
                  best_ff <= clus_ff;
               end
               clus_ff <= last_clus ? '0 : clus_ff + 1'b1;
            end else begin
               acc_ff  <= acc_sum;
               feat_ff <= feat_ff + 1'b1;
            end
         S_LLOAD: begin
            xw_ff  <= dist_mem[clus_ff];
            msb_ff <= 6'(DIST_W - 1);
         end
         S_LNORM:
            if (xw_ff[DIST_W-1]) begin
               m_ff    <= xw_ff[DIST_W-1:DIST_W-MANT_W];
               step_ff <= '0;
               frac_ff <= '0;
            end else begin
               xw_ff  <= xw_ff << 1;
               msb_ff <= msb_ff - 6'd1;
            end
         S_LADJ: begin
            m_ff    <= m_sq;
            frac_ff <= frac_sq;
            step_ff <= step_ff + 4'd1;
            if (step_ff == 4'd15) begin
               lg_mem[clus_ff] <= lg_new;
               if (lg_new < lmin_ff) lmin_ff <= lg_new;
               clus_ff <= last_clus ? '0 : clus_ff + 1'b1;
            end
         end
         S_EADJ: begin
            frac_ff  <= e_val[15:0];
            big_ff   <= (|e_val[26:21]) || (e_val[20:16] == 5'd31);
            shamt_ff <= e_val[20:16];
            m_ff     <= 31'h4000_0000;
            step_ff  <= '0;
         end
         S_WADJ: begin
            if (frac_ff[4'd15 - step_ff]) m_ff <= prod_ff[60:30];
            step_ff <= step_ff + 4'd1;
         end
         S_WEND: begin
            w_mem[clus_ff] <= w_val;
            total_ff <= total_ff + {4'd0, w_val};
            clus_ff  <= last_clus ? '0 : clus_ff + 1'b1;
         end
         S_DIVWAIT:
            if (div_done) begin
               memb_mem[clus_ff] <= div_quot;
               if (clus_ff == '0 || div_quot > bestv_ff) begin
                  bestv_ff <= div_quot;
                  best_ff  <= clus_ff;
               end
               clus_ff <= last_clus ? '0 : clus_ff + 1'b1;
            end
         S_EMIT: if (rsp_fire) clus_ff <= clus_ff + 1'b1;
         default: ;
      endcase
   end

   fme_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   fme_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .num     (div_num),
      .den     (total_ff),
      .done_ff (div_done),
      .quot_ff (div_quot)
   );

   fme_cmem u_cmem (
      .clock (clock),
      .reset (reset),
      .we    (cmem_we),
      .waddr ({req_data.cluster_index, req_data.feature_index}),
      .wdata (req_data.feature_value),
      .raddr ({clus_ff, feat_ff}),
      .rdata (cmem_rdata)
   );

`ifndef SYNTH
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while results pending");
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last) |=> req_ready)
      else $error("block not idle after last beat");
   a_memb_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.membership <= 16'h8000))
      else $error("membership above one");
   a_hit_onehot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.exact_hit) |->
      (rsp_data.membership == 16'h0000 || rsp_data.membership == 16'h8000))
      else $error("exact hit result not one-hot");
`endif
endmodule
`default_nettype wire
